@@ rtl/spsl_pkg.sv @@
`timescale 1ns / 1ps

package spsl_pkg;

    localparam int DEF_COORD_BITS = 16;
    localparam int SPEED_BITS     = 16;
    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int RANGE_BITS     = 16;
    localparam int DIV_STEPS      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_FAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_NEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONE_TAN   = 2'd2;

    localparam logic [CFG_BITS-1:0] RST_RANGE_FAR  = 16'd1000;
    localparam logic [CFG_BITS-1:0] RST_RANGE_NEAR = 16'd300;
    localparam logic [CFG_BITS-1:0] RST_CONE_TAN   = 16'd148;

    typedef enum logic [1:0] {
        ACT_PASS  = 2'd0,
        ACT_SCALE = 2'd1,
        ACT_STOP  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CONE,
        S_CHK,
        S_YY,
        S_ACC,
        S_FIN,
        S_SQRT,
        S_CMP,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ rtl/spsl_if.sv @@
`timescale 1ns / 1ps

interface spsl_pt_if #(
    parameter int COORD_BITS = spsl_pkg::DEF_COORD_BITS
);
    logic                              valid;
    logic                              ready;
    logic signed [COORD_BITS-1:0]      point_x;
    logic signed [COORD_BITS-1:0]      point_y;
    logic                              scan_end;
    logic                              point_valid;
    logic signed [spsl_pkg::SPEED_BITS-1:0] desired_speed;

    modport source (output valid, point_x, point_y, scan_end, point_valid, desired_speed,
                    input ready);
    modport sink   (input valid, point_x, point_y, scan_end, point_valid, desired_speed,
                    output ready);
endinterface

interface spsl_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [spsl_pkg::SPEED_BITS-1:0] limited_speed;
    logic [spsl_pkg::RANGE_BITS-1:0]        nearest_range_mm;
    logic                                   obstacle_found;
    logic [1:0]                             action;

    modport source (output valid, limited_speed, nearest_range_mm, obstacle_found, action,
                    input ready);
    modport sink   (input valid, limited_speed, nearest_range_mm, obstacle_found, action,
                    output ready);
endinterface

interface spsl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [spsl_pkg::CFG_IDX_W-1:0]   index;
    logic [spsl_pkg::CFG_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/sector_proximity_speed_limiter.sv @@
`timescale 1ns / 1ps
// Steps: a point is scaled by the cone tangent, checked against the cone and, when inside it, squared and
// folded into the scan minimum. A scan end then goes straight to the done state when no point qualified,
// else takes a COORD_BITS-bit square root (one root bit a cycle), compares the range, and runs a 32-step division
// (one quotient bit a cycle) when the speed is scaled. The done state holds while the output register is full.
// One item in flight at a time: ready is high only in the idle state.
// Synchronous active-low reset restores the register defaults and clears the scan minimum.
module sector_proximity_speed_limiter #(
    parameter int COORD_BITS = spsl_pkg::DEF_COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spsl_pt_if.sink           i_pt,
    spsl_res_if.source        o_res,
    spsl_cfg_if.sink          i_cfg
);

    localparam int CB    = COORD_BITS;
    localparam int MW    = (CB > spsl_pkg::CFG_BITS) ? CB : spsl_pkg::CFG_BITS;
    localparam int PW    = 2 * MW;
    localparam int SQW   = 2 * CB;
    localparam int SW    = MW + 3;
    localparam int STEPS = (CB > spsl_pkg::DIV_STEPS) ? CB : spsl_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);
    localparam int SB    = spsl_pkg::SPEED_BITS;
    localparam int RB    = spsl_pkg::RANGE_BITS;

    spsl_pkg::t_state  r_state, n_state;
    spsl_pkg::t_action r_action;

    logic [spsl_pkg::CFG_BITS-1:0] r_far, r_near, r_tan;
    logic [SQW-1:0]                r_near_sq;
    logic                          r_any;
    logic                          r_out_valid;

    logic signed [CB-1:0] r_x;
    logic [CB-1:0]        r_ay;
    logic                 r_end;
    logic signed [SB-1:0] r_desired;
    logic [PW-1:0]        r_prod;
    logic [SQW-1:0]       r_sq;
    logic [SQW-1:0]       r_sqv;
    logic [SW-1:0]        r_rem;
    logic [CB-1:0]        r_root;
    logic [SB-1:0]        r_q;
    logic [CNT_W-1:0]     r_cnt;

    logic signed [SB-1:0] r_out_speed;
    logic [RB-1:0]        r_out_range;
    logic                 r_out_found;
    spsl_pkg::t_action    r_out_action;

    logic                 pt_acc;
    logic                 out_go;
    logic [MW-1:0]        mul_a, mul_b;
    logic [PW-1:0]        mul_p;
    logic [SW-1:0]        sub_a, sub_b;
    logic [SW:0]          sub_full;
    logic                 sub_ok;
    logic                 x_pos;
    logic                 in_cone;
    logic [SQW-1:0]       sq_sum;
    logic [MW-1:0]        rng;
    logic                 scale_hit, stop_hit;
    logic [SB-1:0]        mag;
    logic [SB-1:0]        den;
    logic [CB-1:0]        ay_in;
    logic                 last_sqrt, last_div;
    logic signed [SB-1:0] speed;
    logic [RB-1:0]        range_sat;

    assign pt_acc   = i_pt.valid && i_pt.ready;
    assign out_go   = !r_out_valid || o_res.ready;
    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ok   = !sub_full[SW];
    assign x_pos    = !r_x[CB-1] && (|r_x);
    assign in_cone  = x_pos && (PW'({r_ay, 8'b0}) < r_prod);
    assign sq_sum   = r_sq + r_prod[SQW-1:0];
    assign rng      = MW'(r_root);
    assign scale_hit = (rng < MW'(r_far)) && (rng > MW'(r_near));
    assign stop_hit  = (rng <= MW'(r_near));
    assign mag      = r_desired[SB-1] ? SB'(-r_desired) : SB'(r_desired);
    assign den      = r_far - r_near;
    assign ay_in    = i_pt.point_y[CB-1] ? CB'(-i_pt.point_y) : CB'(i_pt.point_y);
    assign last_sqrt = (r_cnt == CNT_W'(CB - 1));
    assign last_div  = (r_cnt == CNT_W'(spsl_pkg::DIV_STEPS - 1));
    assign range_sat = (rng > MW'({RB{1'b1}})) ? {RB{1'b1}} : rng[RB-1:0];

    assign i_cfg.ready = 1'b1;
    assign i_pt.ready  = (r_state == spsl_pkg::S_IDLE);

    assign o_res.valid            = r_out_valid;
    assign o_res.limited_speed    = r_out_speed;
    assign o_res.nearest_range_mm = r_out_range;
    assign o_res.obstacle_found   = r_out_found;
    assign o_res.action           = r_out_action;

    always_comb begin
        n_state = r_state;
        case (r_state)
            spsl_pkg::S_IDLE: begin
                if (pt_acc) begin
                    if (i_pt.point_valid) begin
                        n_state = spsl_pkg::S_CONE;
                    end else if (i_pt.scan_end) begin
                        n_state = spsl_pkg::S_FIN;
                    end
                end
            end
            spsl_pkg::S_CONE: n_state = spsl_pkg::S_CHK;
            spsl_pkg::S_CHK: begin
                if (in_cone) begin
                    n_state = spsl_pkg::S_YY;
                end else begin
                    n_state = r_end ? spsl_pkg::S_FIN : spsl_pkg::S_IDLE;
                end
            end
            spsl_pkg::S_YY:  n_state = spsl_pkg::S_ACC;
            spsl_pkg::S_ACC: n_state = r_end ? spsl_pkg::S_FIN : spsl_pkg::S_IDLE;
            spsl_pkg::S_FIN: n_state = r_any ? spsl_pkg::S_SQRT : spsl_pkg::S_DONE;
            spsl_pkg::S_SQRT: begin
                if (last_sqrt) begin
                    n_state = spsl_pkg::S_CMP;
                end
            end
            spsl_pkg::S_CMP: n_state = scale_hit ? spsl_pkg::S_DIV : spsl_pkg::S_DONE;
            spsl_pkg::S_DIV: begin
                if (last_div) begin
                    n_state = spsl_pkg::S_DONE;
                end
            end
            spsl_pkg::S_DONE: begin
                if (out_go) begin
                    n_state = spsl_pkg::S_IDLE;
                end
            end
            default: n_state = spsl_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        sub_a = '0;
        sub_b = '0;
        case (r_state)
            spsl_pkg::S_CONE: begin
                mul_a = MW'(unsigned'(r_x));
                mul_b = MW'(r_tan);
            end
            spsl_pkg::S_CHK: begin
                mul_a = MW'(unsigned'(r_x));
                mul_b = MW'(unsigned'(r_x));
            end
            spsl_pkg::S_YY: begin
                mul_a = MW'(r_ay);
                mul_b = MW'(r_ay);
            end
            spsl_pkg::S_SQRT: begin
                sub_a = {r_rem[SW-3:0], r_sqv[SQW-1 -: 2]};
                sub_b = SW'({r_root, 2'b01});
            end
            spsl_pkg::S_CMP: begin
                mul_a = MW'(rng - MW'(r_near));
                mul_b = MW'(mag);
            end
            spsl_pkg::S_DIV: begin
                sub_a = {r_rem[SW-2:0], r_prod[spsl_pkg::DIV_STEPS-1]};
                sub_b = SW'(den);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        case (r_action)
            spsl_pkg::ACT_SCALE: speed = r_desired[SB-1] ? SB'(-r_q) : signed'(r_q);
            spsl_pkg::ACT_STOP:  speed = '0;
            default:             speed = r_desired;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spsl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_near_sq   <= '1;
            r_any       <= 1'b0;
            r_far       <= spsl_pkg::RST_RANGE_FAR;
            r_near      <= spsl_pkg::RST_RANGE_NEAR;
            r_tan       <= spsl_pkg::RST_CONE_TAN;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    spsl_pkg::CFG_RANGE_FAR:  r_far  <= i_cfg.data;
                    spsl_pkg::CFG_RANGE_NEAR: r_near <= i_cfg.data;
                    spsl_pkg::CFG_CONE_TAN:   r_tan  <= i_cfg.data;
                    default:                  r_far  <= r_far;
                endcase
            end
            if (r_state == spsl_pkg::S_ACC) begin
                if (!r_any || (sq_sum < r_near_sq)) begin
                    r_near_sq <= sq_sum;
                end
                r_any <= 1'b1;
            end
            if (r_state == spsl_pkg::S_DONE && out_go) begin
                r_out_valid <= 1'b1;
                r_near_sq   <= '1;
                r_any       <= 1'b0;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            spsl_pkg::S_IDLE: begin
                if (pt_acc) begin
                    r_x       <= i_pt.point_x;
                    r_ay      <= ay_in;
                    r_end     <= i_pt.scan_end;
                    r_desired <= i_pt.desired_speed;
                end
            end
            spsl_pkg::S_CONE: r_prod <= mul_p;
            spsl_pkg::S_CHK:  r_prod <= mul_p;
            spsl_pkg::S_YY: begin
                r_sq   <= r_prod[SQW-1:0];
                r_prod <= mul_p;
            end
            spsl_pkg::S_FIN: begin
                r_rem    <= '0;
                r_root   <= '0;
                r_cnt    <= '0;
                r_sqv    <= r_near_sq;
                r_action <= spsl_pkg::ACT_PASS;
            end
            spsl_pkg::S_SQRT: begin
                r_rem  <= sub_ok ? sub_full[SW-1:0] : sub_a;
                r_root <= {r_root[CB-2:0], sub_ok};
                r_sqv  <= r_sqv << 2;
                r_cnt  <= r_cnt + 1'b1;
            end
            spsl_pkg::S_CMP: begin
                r_prod <= mul_p;
                r_rem  <= '0;
                r_cnt  <= '0;
                r_q    <= '0;
                if (scale_hit) begin
                    r_action <= spsl_pkg::ACT_SCALE;
                end else if (stop_hit) begin
                    r_action <= spsl_pkg::ACT_STOP;
                end else begin
                    r_action <= spsl_pkg::ACT_PASS;
                end
            end
            spsl_pkg::S_DIV: begin
                r_rem  <= sub_ok ? sub_full[SW-1:0] : sub_a;
                r_q    <= {r_q[SB-2:0], sub_ok};
                r_prod <= r_prod << 1;
                r_cnt  <= r_cnt + 1'b1;
            end
            spsl_pkg::S_DONE: begin
                if (out_go) begin
                    r_out_speed  <= speed;
                    r_out_range  <= r_any ? range_sat : '0;
                    r_out_found  <= r_any;
                    r_out_action <= r_action;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule

@@ test/sector_proximity_speed_limiter_tb.sv @@
`timescale 1ns / 1ps

typedef struct {
    logic signed [spsl_pkg::DEF_COORD_BITS-1:0] x;
    logic signed [spsl_pkg::DEF_COORD_BITS-1:0] y;
    logic                                       scan_end;
    logic                                       point_valid;
    logic signed [spsl_pkg::SPEED_BITS-1:0]     speed;
} t_scan_beat;

typedef struct packed {
    logic signed [spsl_pkg::SPEED_BITS-1:0] speed;
    logic [spsl_pkg::RANGE_BITS-1:0]        range;
    logic                                   found;
    spsl_pkg::t_action                      action;
} t_speed_cmd;

class t_limiter_scoreboard;
    int         far_mm;
    int         near_mm;
    int         cone_tan;
    longint     min_square;
    bit         seen_in_cone;
    t_speed_cmd expected_cmds[$];
    int         errors;

    function new();
        far_mm       = int'(spsl_pkg::RST_RANGE_FAR);
        near_mm      = int'(spsl_pkg::RST_RANGE_NEAR);
        cone_tan     = int'(spsl_pkg::RST_CONE_TAN);
        min_square   = 64'hFFFF_FFFF;
        seen_in_cone = 1'b0;
        errors       = 0;
    endfunction

    function void set_reg(logic [spsl_pkg::CFG_IDX_W-1:0] idx, logic [spsl_pkg::CFG_BITS-1:0] val);
        case (idx)
            spsl_pkg::CFG_RANGE_FAR:  far_mm = int'(val);
            spsl_pkg::CFG_RANGE_NEAR: near_mm = int'(val);
            spsl_pkg::CFG_CONE_TAN:   cone_tan = int'(val);
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction

    function longint floor_root(longint sq);
        longint root;
        longint trial;
        root = 0;
        for (int b = 16; b >= 0; b--) begin
            trial = root + (longint'(1) << b);
            if (trial * trial <= sq) root = trial;
        end
        return root;
    endfunction

    function void take_point(t_scan_beat b);
        longint     x;
        longint     ay;
        longint     sq;
        longint     speed;
        longint     mag;
        longint     range;
        t_speed_cmd cmd;
        x  = longint'(b.x);
        ay = longint'(b.y);
        if (ay < 0) ay = -ay;
        if (b.point_valid && x > 0 && ay * 256 < x * cone_tan) begin
            sq = x * x + ay * ay;
            if (!seen_in_cone || sq < min_square) min_square = sq;
            seen_in_cone = 1'b1;
        end
        if (!b.scan_end) return;
        speed      = longint'(b.speed);
        range      = 0;
        cmd.action = spsl_pkg::ACT_PASS;
        if (seen_in_cone) begin
            range = floor_root(min_square);
            if (range < far_mm && range > near_mm) begin
                mag        = (speed < 0) ? -speed : speed;
                mag        = (range - near_mm) * mag / (far_mm - near_mm);
                speed      = (speed < 0) ? -mag : mag;
                cmd.action = spsl_pkg::ACT_SCALE;
            end else if (range <= near_mm) begin
                speed      = 0;
                cmd.action = spsl_pkg::ACT_STOP;
            end
        end
        cmd.speed = 16'(speed);
        cmd.range = 16'(range);
        cmd.found = seen_in_cone;
        expected_cmds.push_back(cmd);
        min_square   = 64'hFFFF_FFFF;
        seen_in_cone = 1'b0;
    endfunction

    function void check_command(t_speed_cmd got);
        t_speed_cmd want;
        if (expected_cmds.size() == 0) begin
            $display("%0t: unexpected beat speed=%0d range=%0d found=%0d action=%0d",
                     $time, got.speed, got.range, got.found, got.action);
            errors++;
            return;
        end
        want = expected_cmds.pop_front();
        if (got.speed !== want.speed || got.range !== want.range ||
            got.found !== want.found || got.action !== want.action) begin
            $display("%0t: expected speed=%0d range=%0d found=%0d action=%0d", $time,
                     want.speed, want.range, want.found, want.action);
            $display("%0t: actual   speed=%0d range=%0d found=%0d action=%0d", $time,
                     got.speed, got.range, got.found, got.action);
            errors++;
        end
    endfunction
endclass

module sector_proximity_speed_limiter_tb;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 66;
    localparam int DRAIN_CYCLES = 64;
    localparam int LONG_HOLD    = 400;
    localparam int STALL_LIMIT  = 3000;

    int far_list[PHASES]  = '{1000, 65535, 0, 500, 2000, 1200, 300, 65535};
    int near_list[PHASES] = '{300, 0, 0, 800, 100, 400, 300, 65535};
    int tan_list[PHASES]  = '{148, 65535, 0, 256, 1024, 148, 40000, 512};

    logic i_clk = 1'b0;
    logic i_rst_n;

    spsl_pt_if #(.COORD_BITS(spsl_pkg::DEF_COORD_BITS)) point_bus ();
    spsl_res_if                                         cmd_bus ();
    spsl_cfg_if                                         cfg_bus ();

    sector_proximity_speed_limiter #(
        .COORD_BITS(spsl_pkg::DEF_COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pt   (point_bus),
        .o_res  (cmd_bus),
        .i_cfg  (cfg_bus)
    );

    t_limiter_scoreboard sb;
    int burst_left = 0;
    int items_sent = 0;
    int cmds_seen  = 0;
    int stall_cycles = 0;
    bit held_off = 1'b0;

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin : cmd_monitor
        t_speed_cmd got;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            got.speed  = cmd_bus.limited_speed;
            got.range  = cmd_bus.nearest_range_mm;
            got.found  = cmd_bus.obstacle_found;
            got.action = spsl_pkg::t_action'(cmd_bus.action);
            sb.check_command(got);
            cmds_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (point_bus.valid && point_bus.ready) ||
            (cmd_bus.valid && cmd_bus.ready) || (cfg_bus.valid && cfg_bus.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : cmd_ready_pattern
        int mode;
        int n;
        cmd_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && cmds_seen >= 30) begin
                held_off = 1'b1;
                cmd_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            n    = $urandom_range(5, 40);
            repeat (n) begin
                case (mode)
                    0:       cmd_bus.ready <= 1'b1;
                    1:       cmd_bus.ready <= 1'($urandom_range(0, 1));
                    default: cmd_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    function automatic t_scan_beat beat(int x, int y, bit last, bit pv, int spd);
        t_scan_beat b;
        b.x           = 16'(x);
        b.y           = 16'(y);
        b.scan_end    = last;
        b.point_valid = pv;
        b.speed       = 16'(spd);
        return b;
    endfunction

    function automatic t_scan_beat shaped_point();
        t_scan_beat b;
        longint     reach;
        longint     x;
        longint     lim;
        longint     y;
        b.scan_end    = 1'b0;
        b.point_valid = 1'b1;
        b.speed       = 16'($urandom());
        reach = longint'((sb.far_mm > sb.near_mm) ? sb.far_mm : sb.near_mm) + 300;
        if (reach > 32767) reach = 32767;
        case ($urandom_range(0, 9))
            0: begin
                b.x = 16'($urandom());
                b.y = 16'($urandom());
            end
            1: begin
                b.x           = 16'($urandom());
                b.y           = 16'($urandom());
                b.point_valid = 1'b0;
            end
            default: begin
                x   = longint'($urandom_range(1, int'(reach)));
                lim = (x * sb.cone_tan) >>> 8;
                if (lim > 32767) lim = 32767;
                y = longint'($urandom_range(0, int'(lim)));
                if ($urandom_range(0, 1) == 1) y = -y;
                b.x = 16'(x);
                b.y = 16'(y);
            end
        endcase
        return b;
    endfunction

    task automatic offer_beat(input t_scan_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                point_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        point_bus.valid         <= 1'b1;
        point_bus.point_x       <= b.x;
        point_bus.point_y       <= b.y;
        point_bus.scan_end      <= b.scan_end;
        point_bus.point_valid   <= b.point_valid;
        point_bus.desired_speed <= b.speed;
        @(posedge i_clk);
        while (!point_bus.ready) @(posedge i_clk);
        sb.take_point(b);
        items_sent++;
    endtask

    task automatic random_scan();
        int         len;
        t_scan_beat b;
        if ($urandom_range(0, 9) == 0) begin
            b.x           = 16'($urandom());
            b.y           = 16'($urandom());
            b.scan_end    = 1'($urandom_range(0, 1));
            b.point_valid = 1'($urandom_range(0, 1));
            b.speed       = 16'($urandom());
            offer_beat(b);
        end else begin
            len = $urandom_range(0, 6);
            repeat (len) offer_beat(shaped_point());
            b          = shaped_point();
            b.scan_end = 1'b1;
            if ($urandom_range(0, 1) == 1) b.point_valid = 1'b0;
            case ($urandom_range(0, 7))
                0:       b.speed = 16'sh8000;
                1:       b.speed = 16'sh7FFF;
                2:       b.speed = 16'sh0000;
                default: b.speed = 16'($urandom());
            endcase
            offer_beat(b);
        end
    endtask

    // hold input off until every pending result has drained and the block is idle
    task automatic settle();
        point_bus.valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [spsl_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= 16'(val);
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        sb.set_reg(idx, 16'(val));
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase_goal;
        sb = new();
        i_rst_n                 <= 1'b0;
        point_bus.valid         <= 1'b0;
        point_bus.point_x       <= '0;
        point_bus.point_y       <= '0;
        point_bus.scan_end      <= 1'b0;
        point_bus.point_valid   <= 1'b0;
        point_bus.desired_speed <= '0;
        cfg_bus.valid           <= 1'b0;
        cfg_bus.index           <= spsl_pkg::CFG_RANGE_FAR;
        cfg_bus.data            <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        offer_beat(beat(0, 0, 1, 1, 500));
        offer_beat(beat(500, 0, 0, 0, 123));
        offer_beat(beat(0, 0, 1, 0, -700));
        offer_beat(beat(600, 0, 0, 1, 0));
        offer_beat(beat(-32768, 0, 0, 1, 0));
        offer_beat(beat(32767, -32768, 0, 1, 0));
        offer_beat(beat(400, 100, 1, 1, 1000));
        offer_beat(beat(250, 0, 1, 1, -32768));
        offer_beat(beat(32767, 0, 1, 1, 32767));
        offer_beat(beat(300, 0, 1, 1, -1));
        offer_beat(beat(1000, 0, 1, 1, 777));
        offer_beat(beat(999, 0, 1, 1, -32768));
        offer_beat(beat(301, 0, 1, 1, 32767));
        offer_beat(beat(256, 148, 1, 1, 400));
        offer_beat(beat(256, -147, 1, 1, 400));
        offer_beat(beat(-1, -1, 0, 1, 0));
        offer_beat(beat(32767, 32767, 1, 1, -32768));
        offer_beat(beat(700, -200, 0, 1, 0));
        offer_beat(beat(900, 50, 0, 1, 0));
        offer_beat(beat(0, 0, 1, 0, 32767));

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                write_reg(spsl_pkg::CFG_RANGE_FAR, far_list[phase]);
                write_reg(spsl_pkg::CFG_RANGE_NEAR, near_list[phase]);
                write_reg(spsl_pkg::CFG_CONE_TAN, tan_list[phase]);
            end
            phase_goal = items_sent + PHASE_ITEMS;
            while (items_sent < phase_goal) random_scan();
            offer_beat(beat(0, 0, 1, 0, int'($urandom_range(0, 65535))));
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/spsl_pkg.sv
rtl/spsl_if.sv
rtl/sector_proximity_speed_limiter.sv
test/sector_proximity_speed_limiter_tb.sv
